FILE: hdl/esc_strip_pkg.sv
package esc_strip_pkg;

  localparam logic [7:0] ESC_CODE  = 8'h1b;
  localparam logic [7:0] CH_BRACKET = 8'h5b;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [2:0] PH_NORMAL    = 3'd0;
  localparam logic [2:0] PH_AFTER_ESC = 3'd1;
  localparam logic [2:0] PH_SKIP      = 3'd2;
  localparam logic [2:0] PH_CSI       = 3'd3;
  localparam logic [2:0] PH_CSI_TRAIL = 3'd4;

  localparam logic [1:0] SKIP_EQUALS = 2'd2;
  localparam logic [1:0] SKIP_SHORT  = 2'd1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
  } result_t;

  function automatic logic is_ascii_letter(input logic [7:0] b);
    logic [7:0] u;
    u = b | CASE_BIT;
    return (u >= (CH_UPPER_A | CASE_BIT)) && (u <= (CH_UPPER_Z | CASE_BIT));
  endfunction

  function automatic logic is_sjis_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
  endfunction

endpackage

FILE: hdl/esc_strip_in_if.sv
interface esc_strip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: hdl/esc_strip_out_if.sv
interface esc_strip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_end;

  modport source (output valid, output out_byte, output is_end, input ready);
  modport sink (input valid, input out_byte, input is_end, output ready);
endinterface

FILE: hdl/escape_sequence_stripper.sv
// a result is registered in the output register; throughput is one byte per cycle while
// the skid is empty, set by the single phase and skip-count register update
// a skid register keeps input ready for one result while the output is stalled
// reset: synchronous active-high rst returns the parser to normal text, skip count
// to zero, and empties the output and skid registers
module escape_sequence_stripper
  import esc_strip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  esc_strip_in_if.sink     raw,
  esc_strip_out_if.source  clean
);

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [1:0] skip_left;
  logic [1:0] skip_left_next;
  logic       res_valid;
  result_t    res;

  logic       out_valid;
  result_t    out_data;
  logic       skid_valid;
  result_t    skid_data;

  logic       in_fire;
  logic       out_fire;

  assign raw.ready      = !skid_valid;
  assign in_fire        = raw.valid && raw.ready;
  assign out_fire       = out_valid && clean.ready;
  assign clean.valid    = out_valid;
  assign clean.out_byte = out_data.out_byte;
  assign clean.is_end   = out_data.is_end;

  always_comb begin
    phase_next     = phase;
    skip_left_next = skip_left;
    res_valid      = 1'b0;
    res.out_byte   = raw.in_byte;
    res.is_end     = 1'b0;
    if (raw.in_byte == 8'h00) begin
      phase_next     = PH_NORMAL;
      skip_left_next = 2'd0;
      res_valid      = 1'b1;
      res.is_end     = 1'b1;
    end else begin
      unique case (phase)
        PH_AFTER_ESC: begin
          if (raw.in_byte == CH_BRACKET) begin
            phase_next = PH_CSI;
          end else if (raw.in_byte == CH_EQUALS) begin
            phase_next     = PH_SKIP;
            skip_left_next = SKIP_EQUALS;
          end else if (raw.in_byte == CH_RPAREN || raw.in_byte == CH_BANG) begin
            phase_next     = PH_SKIP;
            skip_left_next = SKIP_SHORT;
          end else begin
            phase_next = PH_NORMAL;
          end
        end
        PH_SKIP: begin
          if (skip_left <= 2'd1) begin
            skip_left_next = 2'd0;
            phase_next     = PH_NORMAL;
          end else begin
            skip_left_next = skip_left - 2'd1;
          end
        end
        PH_CSI: begin
          if (is_ascii_letter(raw.in_byte)) begin
            phase_next = PH_NORMAL;
          end else if (is_sjis_lead(raw.in_byte)) begin
            phase_next = PH_CSI_TRAIL;
          end
        end
        PH_CSI_TRAIL: begin
          phase_next = PH_CSI;
        end
        default: begin
          if (raw.in_byte == ESC_CODE) begin
            phase_next = PH_AFTER_ESC;
          end else begin
            phase_next = PH_NORMAL;
            res_valid  = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NORMAL;
      skip_left <= 2'd0;
    end else if (in_fire) begin
      phase     <= phase_next;
      skip_left <= skip_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid || out_fire) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  a_skip_only_in_skip: assert property (@(posedge clk) disable iff (rst)
    skip_left != 2'd0 |-> phase == PH_SKIP)
    else $error("skip count left over outside the skip phase");

  a_zero_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && raw.in_byte == 8'h00 |=> phase == PH_NORMAL && skip_left == 2'd0 && out_valid)
    else $error("end of text did not reset the parser or give a result");

  a_drop_keeps_out: assert property (@(posedge clk) disable iff (rst)
    in_fire && !res_valid && !out_fire && !skid_valid |=> out_valid == $past(out_valid))
    else $error("dropped byte changed the output register");

endmodule
